### design/aima_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aima_pkg
// Shared widths, CORDIC angle table and pipeline word for the aiming-angle
// datapath.
// ----------------------------------------------------------------------------
package aima_pkg;

    localparam int COORD_W    = 12;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int FRAC_W     = 16;
    localparam int VEC_W      = 32;
    localparam int ANGLE_W    = 17;
    localparam int ROUND_W    = 34;
    localparam int ITERATIONS = 16;
    localparam int TABLE_LEN  = 24;
    localparam int NUM_STAGES = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
    // input stage + micro-rotations + rounding stage
    localparam int LATENCY    = NUM_STAGES + 2;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [VEC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI      = 17'sd16384;
    localparam logic signed [ANGLE_W-1:0] ANGLE_THREE_HALF_PI = 17'sd49152;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN          = -17'sd16383;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX          = 17'sd49152;
    localparam logic signed [ROUND_W-1:0] Z_HALF_TURN        = 34'sd2147483648;
    localparam logic signed [ROUND_W-1:0] ROUND_HALF         = 34'sd32768;

    typedef struct packed {
        logic             valid;
        logic             vert;    // dx is zero, CORDIC result unused
        logic             dx_neg;
        logic             dy_neg;
        logic [VEC_W-1:0] x;
        logic [VEC_W-1:0] y;
        logic [VEC_W-1:0] z;
    } t_vec;

endpackage

### design/aima_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aima_prep
// Input stage: point difference and initial CORDIC vector (|dx|, dy) in
// 32-bit fixed point with 16 fraction bits.
// ----------------------------------------------------------------------------
module aima_prep (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [aima_pkg::COORD_W-1:0]   i_src_x,
    input  logic signed [aima_pkg::COORD_W-1:0]   i_src_y,
    input  logic signed [aima_pkg::COORD_W-1:0]   i_dst_x,
    input  logic signed [aima_pkg::COORD_W-1:0]   i_dst_y,
    output aima_pkg::t_vec                        o_vec
);
    import aima_pkg::*;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic        [DIFF_W-1:0] dx_mag;
    t_vec                     n_vec;
    t_vec                     r_vec;

    always_comb begin
        dx     = DIFF_W'(i_dst_x) - DIFF_W'(i_src_x);
        dy     = DIFF_W'(i_dst_y) - DIFF_W'(i_src_y);
        dx_mag = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);

        n_vec.valid  = i_valid;
        n_vec.vert   = (dx == '0);
        n_vec.dx_neg = dx[DIFF_W-1];
        n_vec.dy_neg = dy[DIFF_W-1];
        n_vec.x      = {{(VEC_W-DIFF_W-FRAC_W){1'b0}}, dx_mag, {FRAC_W{1'b0}}};
        n_vec.y      = {{(VEC_W-DIFF_W-FRAC_W){dy[DIFF_W-1]}}, dy, {FRAC_W{1'b0}}};
        n_vec.z      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec <= '0;
        end else if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

### design/aima_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aima_cordic
// Unrolled CORDIC vectoring pipeline, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module aima_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  aima_pkg::t_vec i_vec,
    output aima_pkg::t_vec o_vec
);
    import aima_pkg::*;

    t_vec r_stg [NUM_STAGES];
    t_vec n_stg [NUM_STAGES];

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
        t_vec             p;
        logic [VEC_W-1:0] xs;
        logic [VEC_W-1:0] ys;

        if (i == 0) begin : g_first
            assign p = i_vec;
        end else begin : g_next
            assign p = r_stg[i-1];
        end

        always_comb begin
            xs = VEC_W'($signed(p.x) >>> i);
            ys = VEC_W'($signed(p.y) >>> i);
            n_stg[i] = p;
            // y >= 0: rotate clockwise, angle grows
            if (!p.y[VEC_W-1]) begin
                n_stg[i].x = p.x + ys;
                n_stg[i].y = p.y - xs;
                n_stg[i].z = p.z + ATAN_TAB[i];
            end else begin
                n_stg[i].x = p.x - ys;
                n_stg[i].y = p.y + xs;
                n_stg[i].z = p.z - ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[i] <= '0;
            end else if (i_en) begin
                r_stg[i] <= n_stg[i];
            end
        end
    end

    assign o_vec = r_stg[NUM_STAGES-1];

endmodule

### design/aima_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aima_round
// Output stage: quadrant fold, round half up to 2*pi/65536 units, vertical
// aim override, output register.
// ----------------------------------------------------------------------------
module aima_round (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  aima_pkg::t_vec                       i_vec,
    output logic                                 o_valid,
    output logic signed [aima_pkg::ANGLE_W-1:0]  o_angle
);
    import aima_pkg::*;

    logic signed [ROUND_W-1:0] z_ext;
    logic signed [ROUND_W-1:0] t_val;
    logic signed [ROUND_W-1:0] t_rnd;
    logic signed [ANGLE_W-1:0] n_angle;
    logic                      r_valid;
    logic signed [ANGLE_W-1:0] r_angle;

    always_comb begin
        z_ext = ROUND_W'($signed(i_vec.z));
        // left half plane: pi - z (z counts counterclockwise from +x)
        t_val = i_vec.dx_neg ? (Z_HALF_TURN - z_ext) : z_ext;
        t_rnd = (t_val + ROUND_HALF) >>> FRAC_W;
        if (i_vec.vert) begin
            n_angle = i_vec.dy_neg ? ANGLE_THREE_HALF_PI : ANGLE_HALF_PI;
        end else begin
            n_angle = t_rnd[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_vec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

endmodule

### design/aim_angle_atan2.sv
`timescale 1ns / 1ps
// Pipeline stages: 1 input stage, 16 CORDIC micro-rotation stages,
// 1 rounding/output stage.
// Throughput: one request per cycle; the whole pipeline holds while the
// output result is stalled.
// Reset clears all stage valid bits and the vector stage registers.
// ----------------------------------------------------------------------------
// aim_angle_atan2
// Aiming angle from a source point to a target point, pipelined CORDIC.
// ----------------------------------------------------------------------------
module aim_angle_atan2 (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [aima_pkg::COORD_W-1:0]  i_src_x,
    input  logic signed [aima_pkg::COORD_W-1:0]  i_src_y,
    input  logic signed [aima_pkg::COORD_W-1:0]  i_dst_x,
    input  logic signed [aima_pkg::COORD_W-1:0]  i_dst_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [aima_pkg::ANGLE_W-1:0]  o_angle
);
    import aima_pkg::*;

    logic en;
    t_vec prep_vec;
    t_vec cordic_vec;

    // advance unless a finished result is held by the sink
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    aima_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_src_x (i_src_x),
        .i_src_y (i_src_y),
        .i_dst_x (i_dst_x),
        .i_dst_y (i_dst_y),
        .o_vec   (prep_vec)
    );

    aima_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vec   (prep_vec),
        .o_vec   (cordic_vec)
    );

    aima_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vec   (cordic_vec),
        .o_valid (o_valid),
        .o_angle (o_angle)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result pending");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> prep_vec.valid)
        else $error("accepted request missing from first stage");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(cordic_vec.valid) && $stable(cordic_vec.z))
        else $error("pipeline moved while stalled");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle >= ANGLE_MIN) && (o_angle <= ANGLE_MAX))
        else $error("angle out of range");

endmodule
